// File: src/egbr_pkg.sv
// Shared types and constants of the Exp-Golomb bitstream reader.
`default_nettype none

package egbr_pkg;

    localparam int BUF_BYTES_DEF = 4096;
    localparam int WORD_BITS     = 32;
    localparam int BYTE_BITS     = 8;
    localparam int LANES         = 4;

    typedef enum logic [3:0] {
        OP_START     = 4'd0,
        OP_APPEND    = 4'd1,
        OP_READ      = 4'd2,
        OP_UE        = 4'd3,
        OP_SE        = 4'd4,
        OP_PEEK      = 4'd5,
        OP_SKIP      = 4'd6,
        OP_ALIGN     = 4'd7,
        OP_BITS_LEFT = 4'd8,
        OP_MORE_DATA = 4'd9
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_LOAD_HI,
        ST_LOAD_LO,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic cap_hi;
        logic cap_win;
    } win_ctl_t;

endpackage

`default_nettype wire

// File: src/egbr_store.sv
// Byte store: rows of four bytes, byte-wide writes, one registered row read per cycle.
`default_nettype none

module egbr_store
    import egbr_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF,
    localparam int AW = $clog2(BUF_BYTES),
    localparam int RW = AW - 2,
    localparam int ROWS = (BUF_BYTES + LANES - 1) / LANES
)(
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [BYTE_BITS-1:0] wr_data,
    input  wire logic [RW-1:0]        rd_row,
    output logic      [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [ROWS];
    logic [WORD_BITS-1:0] rd_data_reg;

    // The lowest byte address of a row sits in its most significant lane.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[AW-1:2]][{~wr_addr[1:0], 3'b000} +: BYTE_BITS] <= wr_data;
        end
        rd_data_reg <= mem[rd_row];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/egbr_window.sv
// Window stage: joins two rows, aligns them to the bit position and masks bits past the end.
`default_nettype none

module egbr_window
    import egbr_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF,
    localparam int CW = $clog2(BUF_BYTES + 1),
    localparam int PW = CW + 3
)(
    input  wire logic                 clk,
    input  wire win_ctl_t             ctl,
    input  wire logic [WORD_BITS-1:0] rd_data,
    input  wire logic [4:0]           shift,
    input  wire logic [PW-1:0]        avail,
    output logic      [WORD_BITS-1:0] window
);

    logic [WORD_BITS-1:0]   hi_reg;
    logic [WORD_BITS-1:0]   win_reg;
    logic [WORD_BITS-1:0]   win_next;
    logic [WORD_BITS-1:0]   mask;
    logic [2*WORD_BITS-1:0] aligned;

    always_comb
    begin
        aligned = {hi_reg, rd_data} << shift;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            mask[WORD_BITS-1-i] = (PW'(i) < avail);
        end
        win_next = aligned[2*WORD_BITS-1 -: WORD_BITS] & mask;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap_hi)
        begin
            hi_reg <= rd_data;
        end
        if (ctl.cap_win)
        begin
            win_reg <= win_next;
        end
    end

    assign window = win_reg;

endmodule

`default_nettype wire

// File: src/egbr_ctrl.sv
// Sequencer and execute stage: positions, fill count, stop bit, error flag and results.
`default_nettype none

module egbr_ctrl
    import egbr_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF,
    localparam int AW = $clog2(BUF_BYTES),
    localparam int RW = AW - 2,
    localparam int CW = $clog2(BUF_BYTES + 1),
    localparam int PW = CW + 3,
    localparam int SW = AW + 3
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [3:0]           opcode,
    input  wire logic [5:0]           count,
    input  wire logic [BYTE_BITS-1:0] byte_in,
    output logic                      busy,
    output logic                      done,
    output logic      [WORD_BITS-1:0] value,
    output logic                      error,
    output logic                      wr_en,
    output logic      [AW-1:0]        wr_addr,
    output logic      [BYTE_BITS-1:0] wr_data,
    output logic      [RW-1:0]        rd_row,
    output win_ctl_t                  win_ctl,
    output logic      [4:0]           shift,
    output logic      [PW-1:0]        avail,
    input  wire logic [WORD_BITS-1:0] window
);

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic                 err_reg, err_next;
    logic [SW-1:0]        stop_reg, stop_next;
    logic                 stop_valid_reg, stop_valid_next;
    logic [5:0]           n_reg, n_next;
    logic                 suffix_reg, suffix_next;
    logic                 done_reg, done_next;
    logic [WORD_BITS-1:0] value_reg, value_next;
    logic                 error_reg, error_next;

    op_t                    op_in;
    logic [PW-1:0]          avail_w;
    logic                   short_w;
    logic [5:0]             take_n;
    logic [5:0]             take_prefix;
    logic [2*WORD_BITS-1:0] shl_w;
    logic [WORD_BITS-1:0]   rd_val;
    logic [5:0]             lz;
    logic [WORD_BITS-1:0]   u_w;
    logic [WORD_BITS-1:0]   m_w;
    logic [WORD_BITS-1:0]   ue_val;
    logic [WORD_BITS-1:0]   se_val;
    logic [2:0]             low_pos;
    logic                   more_w;
    logic                   fill_full;
    logic                   go_suffix;

    assign op_in     = op_t'(opcode);
    assign avail_w   = {fill_reg, 3'b000} - pos_reg;
    assign short_w   = PW'(n_reg) > avail_w;
    assign take_n    = short_w ? avail_w[5:0] : n_reg;
    assign take_prefix = (avail_w < PW'(WORD_BITS)) ? avail_w[5:0] : 6'(WORD_BITS);
    assign shl_w     = {{WORD_BITS{1'b0}}, window} << n_reg;
    assign rd_val    = shl_w[2*WORD_BITS-1 -: WORD_BITS];
    assign fill_full = (fill_reg == CW'(BUF_BYTES));
    assign more_w    = (avail_w != '0) && stop_valid_reg && (pos_reg < PW'(stop_reg));

    // The suffix is below 2^zeros, so the code value plus one is the two joined by an OR.
    assign u_w    = (WORD_BITS'(1) << n_reg[4:0]) | rd_val;
    assign ue_val = u_w - WORD_BITS'(1);
    assign m_w    = {1'b0, u_w[WORD_BITS-1:1]};
    assign se_val = u_w[0] ? (WORD_BITS'(0) - m_w) : m_w;

    always_comb
    begin
        lz = 6'(WORD_BITS);
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (window[i])
            begin
                lz = 6'(WORD_BITS - 1 - i);
            end
        end
    end

    // Bit position of the lowest one bit of the appended byte, counted from its MSB.
    always_comb
    begin
        low_pos = 3'd0;
        for (int j = BYTE_BITS - 1; j >= 0; j--)
        begin
            if (byte_in[j])
            begin
                low_pos = 3'(BYTE_BITS - 1 - j);
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op_in inside {OP_READ, OP_UE, OP_SE, OP_PEEK, OP_SKIP})
                    begin
                        state_next = ST_LOAD_HI;
                    end
                    else if (op_in inside {OP_ALIGN, OP_BITS_LEFT, OP_MORE_DATA})
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_ISSUE:   state_next = ST_LOAD_HI;
            ST_LOAD_HI: state_next = ST_LOAD_LO;
            ST_LOAD_LO: state_next = ST_EXEC;
            ST_EXEC:    state_next = go_suffix ? ST_ISSUE : ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs and register updates.
    always_comb
    begin
        pos_next        = pos_reg;
        fill_next       = fill_reg;
        err_next        = err_reg;
        stop_next       = stop_reg;
        stop_valid_next = stop_valid_reg;
        op_next         = op_reg;
        n_next          = n_reg;
        suffix_next     = suffix_reg;
        value_next      = value_reg;
        error_next      = error_reg;
        done_next       = 1'b0;
        go_suffix       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = fill_reg[AW-1:0];
        wr_data         = byte_in;
        busy            = (state_reg != ST_IDLE);
        win_ctl.cap_hi  = (state_reg == ST_LOAD_HI);
        win_ctl.cap_win = (state_reg == ST_LOAD_LO);
        shift           = pos_reg[4:0];
        avail           = avail_w;
        // While the first row is captured, the row after it is fetched.
        rd_row = (state_reg == ST_LOAD_HI) ? pos_reg[AW+2:5] + RW'(1) : pos_reg[AW+2:5];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = op_in;
                    n_next      = (count > 6'(WORD_BITS)) ? 6'(WORD_BITS) : count;
                    suffix_next = 1'b0;
                    case (op_in)
                        OP_START:
                        begin
                            fill_next       = '0;
                            pos_next        = '0;
                            err_next        = 1'b0;
                            stop_next       = '0;
                            stop_valid_next = 1'b0;
                        end
                        OP_APPEND:
                        begin
                            if (fill_full)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + CW'(1);
                                if (byte_in != '0)
                                begin
                                    stop_next       = {fill_reg[AW-1:0], low_pos};
                                    stop_valid_next = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EXEC:
            begin
                value_next = '0;
                case (op_reg)
                    OP_READ, OP_PEEK, OP_SKIP:
                    begin
                        if (op_reg != OP_SKIP)
                        begin
                            value_next = rd_val;
                        end
                        if (op_reg != OP_PEEK)
                        begin
                            pos_next = pos_reg + PW'(take_n);
                            err_next = err_reg | short_w;
                        end
                    end
                    OP_UE, OP_SE:
                    begin
                        if (!suffix_reg)
                        begin
                            if (!lz[5])
                            begin
                                pos_next    = pos_reg + PW'(lz + 6'd1);
                                n_next      = lz;
                                suffix_next = 1'b1;
                                go_suffix   = 1'b1;
                            end
                            else
                            begin
                                // No one bit among the next 32: the zeros are consumed.
                                pos_next = pos_reg + PW'(take_prefix);
                                err_next = 1'b1;
                            end
                        end
                        else
                        begin
                            pos_next   = pos_reg + PW'(take_n);
                            err_next   = err_reg | short_w;
                            value_next = (op_reg == OP_SE) ? se_val : ue_val;
                        end
                    end
                    OP_ALIGN:
                    begin
                        if (pos_reg[2:0] != 3'd0)
                        begin
                            pos_next = {pos_reg[PW-1:3] + CW'(1), 3'b000};
                        end
                    end
                    OP_BITS_LEFT: value_next = WORD_BITS'(avail_w);
                    OP_MORE_DATA: value_next = WORD_BITS'(more_w);
                    default: ;
                endcase
                done_next  = !go_suffix;
                error_next = err_next;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            fill_reg       <= '0;
            err_reg        <= 1'b0;
            stop_valid_reg <= 1'b0;
            suffix_reg     <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            fill_reg       <= fill_next;
            err_reg        <= err_next;
            stop_valid_reg <= stop_valid_next;
            suffix_reg     <= suffix_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stop_reg  <= stop_next;
        op_reg    <= op_next;
        n_reg     <= n_next;
        value_reg <= value_next;
        error_reg <= error_next;
    end

    assign done  = done_reg;
    assign value = value_reg;
    assign error = error_reg;

endmodule

`default_nettype wire

// File: src/exp_golomb_bitstream_reader_unit.sv
// Top level of the Exp-Golomb bitstream reader.
//
// A transaction is taken when start is high and busy is low. Start and append
// leave busy low, so another transaction can follow at once; appends give no
// result. For read, peek, skip and ue/se with no one bit in the next 32 bits,
// the byte store is read twice (two 32-bit rows hold every bit a command can
// need from any bit offset), the rows are aligned and masked, and the execute
// cycle updates the position. A ue or se with a one bit in its prefix reads
// the store a second time for its suffix. Align, bits_left and more_data do
// not touch the store. Each result appears on value and error while done is
// high for exactly one cycle, and it cannot be held off. The store is not
// cleared after reset or start; only bytes appended since the last start are
// ever read.
`default_nettype none

module exp_golomb_bitstream_reader_unit
    import egbr_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF,
    localparam int AW = $clog2(BUF_BYTES),
    localparam int RW = AW - 2,
    localparam int CW = $clog2(BUF_BYTES + 1),
    localparam int PW = CW + 3
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [3:0]           opcode,
    input  wire logic [5:0]           count,
    input  wire logic [BYTE_BITS-1:0] byte_in,
    output logic                      busy,
    output logic                      done,
    output logic      [WORD_BITS-1:0] value,
    output logic                      error
);

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [BYTE_BITS-1:0] wr_data;
    logic [RW-1:0]        rd_row;
    logic [WORD_BITS-1:0] rd_data;
    win_ctl_t             win_ctl;
    logic [4:0]           shift;
    logic [PW-1:0]        avail;
    logic [WORD_BITS-1:0] window;

    egbr_store #(.BUF_BYTES(BUF_BYTES)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_row  (rd_row),
        .rd_data (rd_data)
    );

    egbr_window #(.BUF_BYTES(BUF_BYTES)) u_window (
        .clk     (clk),
        .ctl     (win_ctl),
        .rd_data (rd_data),
        .shift   (shift),
        .avail   (avail),
        .window  (window)
    );

    egbr_ctrl #(.BUF_BYTES(BUF_BYTES)) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .opcode  (opcode),
        .count   (count),
        .byte_in (byte_in),
        .busy    (busy),
        .done    (done),
        .value   (value),
        .error   (error),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_row  (rd_row),
        .win_ctl (win_ctl),
        .shift   (shift),
        .avail   (avail),
        .window  (window)
    );

endmodule

`default_nettype wire

// File: src/egbr_checker.sv
// Port-level checks of the bitstream reader's timing, bound to the top level.
`default_nettype none

module egbr_checker
    import egbr_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic [3:0]           opcode,
    input wire logic                 busy,
    input wire logic                 done
);

    // Results are strobed only once the block has gone back to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a transaction in progress");

    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_START || opcode == OP_APPEND)) |=> !busy)
        else $error("start or append transaction made the block busy");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_READ || opcode == OP_PEEK || opcode == OP_SKIP))
        |-> ##4 done)
        else $error("read, peek or skip result not on time");

    a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_ALIGN || opcode == OP_BITS_LEFT
                            || opcode == OP_MORE_DATA))
        |-> ##2 done)
        else $error("align, bits_left or more_data result not on time");

endmodule

bind exp_golomb_bitstream_reader_unit egbr_checker u_egbr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (opcode),
    .busy   (busy),
    .done   (done)
);

`default_nettype wire

// File: dv/exp_golomb_bitstream_reader_unit_checker.sv
// Result predictor and scoreboard for the Exp-Golomb bitstream reader.
module exp_golomb_bitstream_reader_unit_checker
    import egbr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic [3:0]           opcode,
    input  wire logic [5:0]           count,
    input  wire logic [BYTE_BITS-1:0] byte_in,
    input  wire logic                 done,
    input  wire logic [WORD_BITS-1:0] value,
    input  wire logic                 error,
    output int                        mismatch_count,
    output int                        replies_outstanding,
    output int                        replies_checked
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [3:0]           opcode;
        logic [WORD_BITS-1:0] value;
        logic                 error;
    } reply_t;

    reply_t predicted_replies[$];

    // Shadow of the reader's buffer and read position.
    logic [BYTE_BITS-1:0] shadow_bytes [BUF_BYTES_DEF];
    int unsigned          fill_level;
    int unsigned          rd_byte;
    int unsigned          rd_bit;
    int unsigned          last_one_at;
    bit                   stop_seen;
    bit                   sticky_err;

    function automatic bit next_bit(inout bit exhausted);
        bit b;
        if (rd_byte >= fill_level || rd_byte >= BUF_BYTES_DEF)
        begin
            sticky_err = 1'b1;
            exhausted  = 1'b1;
            return 1'b0;
        end
        b      = shadow_bytes[rd_byte][7 - rd_bit];
        rd_bit = (rd_bit + 1) & 7;
        if (rd_bit == 0)
        begin
            rd_byte++;
        end
        return b;
    endfunction

    function automatic logic [WORD_BITS-1:0] pull_bits(input int unsigned n);
        logic [WORD_BITS-1:0] v;
        bit                   exhausted;
        v         = '0;
        exhausted = 1'b0;
        repeat (n)
        begin
            v = {v[WORD_BITS-2:0], next_bit(exhausted)};
        end
        return v;
    endfunction

    function automatic logic [WORD_BITS-1:0] pull_ue();
        int unsigned zeros;
        bit          exhausted;
        zeros     = 0;
        exhausted = 1'b0;
        while (zeros < WORD_BITS)
        begin
            if (next_bit(exhausted))
            begin
                break;
            end
            // The buffer ran dry while the prefix was still being counted.
            if (exhausted)
            begin
                return '0;
            end
            zeros++;
        end
        if (zeros >= WORD_BITS)
        begin
            sticky_err = 1'b1;
            return '0;
        end
        return ((32'd1 << zeros) - 32'd1) + pull_bits(zeros);
    endfunction

    function automatic int unsigned bits_remaining();
        if (rd_byte >= fill_level)
        begin
            return 0;
        end
        return (fill_level - rd_byte) * BYTE_BITS - rd_bit;
    endfunction

    task automatic decode_command(input logic [3:0] op, input logic [5:0] cnt,
                                  input logic [BYTE_BITS-1:0] din,
                                  output bit produces, output reply_t reply);
        int unsigned          n;
        int unsigned          bp;
        int unsigned          bi;
        int unsigned          lsb;
        bit                   b;
        logic [WORD_BITS-1:0] v;
        logic [WORD_BITS-1:0] k;
        logic [WORD_BITS-1:0] mag;
        n        = (cnt > WORD_BITS) ? WORD_BITS : cnt;
        v        = '0;
        produces = 1'b1;
        case (op)
            OP_START:
            begin
                fill_level  = 0;
                rd_byte     = 0;
                rd_bit      = 0;
                sticky_err  = 1'b0;
                last_one_at = 0;
                stop_seen   = 1'b0;
                produces    = 1'b0;
            end
            OP_APPEND:
            begin
                if (fill_level >= BUF_BYTES_DEF)
                begin
                    sticky_err = 1'b1;
                end
                else
                begin
                    shadow_bytes[fill_level] = din;
                    // The last one bit appended marks the rbsp stop bit.
                    if (din != '0)
                    begin
                        lsb = 0;
                        while (!din[lsb])
                        begin
                            lsb++;
                        end
                        last_one_at = fill_level * BYTE_BITS + 7 - lsb;
                        stop_seen   = 1'b1;
                    end
                    fill_level++;
                end
                produces = 1'b0;
            end
            OP_READ:
            begin
                v = pull_bits(n);
            end
            OP_UE:
            begin
                v = pull_ue();
            end
            OP_SE:
            begin
                k   = pull_ue();
                mag = (k >> 1) + k[0];
                v   = k[0] ? mag : -mag;
            end
            OP_PEEK:
            begin
                bp = rd_byte;
                bi = rd_bit;
                repeat (n)
                begin
                    b = 1'b0;
                    if (bp < fill_level && bp < BUF_BYTES_DEF)
                    begin
                        b  = shadow_bytes[bp][7 - bi];
                        bi = (bi + 1) & 7;
                        if (bi == 0)
                        begin
                            bp++;
                        end
                    end
                    v = {v[WORD_BITS-2:0], b};
                end
            end
            OP_SKIP:
            begin
                v = pull_bits(n);
                v = '0;
            end
            OP_ALIGN:
            begin
                if (rd_bit != 0)
                begin
                    rd_bit = 0;
                    rd_byte++;
                end
            end
            OP_BITS_LEFT:
            begin
                v = bits_remaining();
            end
            OP_MORE_DATA:
            begin
                if (bits_remaining() != 0 && stop_seen)
                begin
                    v = (rd_byte * BYTE_BITS + rd_bit < last_one_at) ? 32'd1 : 32'd0;
                end
            end
            default:
            begin
                produces = 1'b0;
            end
        endcase
        reply.opcode = op;
        reply.value  = v;
        reply.error  = sticky_err;
    endtask

    always @(posedge clk)
    begin : watch_channels
        reply_t oldest;
        reply_t fresh;
        bit     produces;
        if (!rst_n)
        begin
            predicted_replies.delete();
            fill_level  = 0;
            rd_byte     = 0;
            rd_bit      = 0;
            sticky_err  = 1'b0;
            last_one_at = 0;
            stop_seen   = 1'b0;
        end
        else
        begin
            // A result strobed at this edge belongs to an earlier transaction,
            // so it is checked before any transaction accepted at the same edge.
            if (done)
            begin
                if (predicted_replies.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("Unexpected result: value %h error %b", value, error);
                    end
                end
                else
                begin
                    oldest = predicted_replies.pop_front();
                    replies_checked++;
                    if (value !== oldest.value || error !== oldest.error)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display({"Mismatch on opcode %0d: value exp %h got %h,",
                                      " error exp %b got %b"},
                                     oldest.opcode, oldest.value, value, oldest.error,
                                     error);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                decode_command(opcode, count, byte_in, produces, fresh);
                if (produces)
                begin
                    predicted_replies.push_back(fresh);
                end
            end
        end
        replies_outstanding = predicted_replies.size();
    end

endmodule

// File: dv/exp_golomb_bitstream_reader_unit_tb.sv
// Stimulus and verdict for the Exp-Golomb bitstream reader.
module exp_golomb_bitstream_reader_unit_tb;
    import egbr_pkg::*;

    localparam int         CLK_HALF        = 4;
    localparam int         RESET_CYCLES    = 8;
    localparam int         STALL_LIMIT     = 1000;
    localparam int         TAIL_CYCLES     = 16;
    localparam int         ITEMS_PER_PHASE = 350;
    localparam logic [3:0] OP_FIRST_UNUSED = 4'hA;
    localparam logic [3:0] OP_LAST_UNUSED  = 4'hF;

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 start   = 1'b0;
    logic [3:0]           opcode  = '0;
    logic [5:0]           count   = '0;
    logic [BYTE_BITS-1:0] byte_in = '0;
    wire                  busy;
    wire                  done;
    wire [WORD_BITS-1:0]  value;
    wire                  error;

    int mismatch_count;
    int replies_outstanding;
    int replies_checked;
    int idle_pct;
    int commands_sent;
    int stall_cycles;

    exp_golomb_bitstream_reader_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .opcode  (opcode),
        .count   (count),
        .byte_in (byte_in),
        .busy    (busy),
        .done    (done),
        .value   (value),
        .error   (error)
    );

    exp_golomb_bitstream_reader_unit_checker i_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .opcode              (opcode),
        .count               (count),
        .byte_in             (byte_in),
        .done                (done),
        .value               (value),
        .error               (error),
        .mismatch_count      (mismatch_count),
        .replies_outstanding (replies_outstanding),
        .replies_checked     (replies_checked)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Ends the run if no transaction is accepted and no result appears for too long.
    always @(posedge clk)
    begin
        if (rst_n && !((start && !busy) || done))
        begin
            stall_cycles++;
        end
        else
        begin
            stall_cycles = 0;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding", replies_outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_command(input logic [3:0] op, input logic [5:0] cnt,
                                input logic [BYTE_BITS-1:0] din);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        opcode  <= op;
        count   <= cnt;
        byte_in <= din;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (op <= OP_MORE_DATA)
        begin
            commands_sent++;
        end
    endtask

    task automatic wait_for_replies();
        start <= 1'b0;
        @(posedge clk);
        while (replies_outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [5:0] rand_count();
        // Now and then a count above 32, which the reader clamps.
        if ($urandom_range(9) == 0)
        begin
            return 6'($urandom_range(63, 33));
        end
        return 6'($urandom_range(32, 0));
    endfunction

    task automatic random_command();
        int         pick;
        logic [3:0] op;
        pick = $urandom_range(99);
        if (pick < 28)
        begin
            op = OP_UE;
        end
        else if (pick < 46)
        begin
            op = OP_SE;
        end
        else if (pick < 58)
        begin
            op = OP_READ;
        end
        else if (pick < 66)
        begin
            op = OP_PEEK;
        end
        else if (pick < 72)
        begin
            op = OP_SKIP;
        end
        else if (pick < 78)
        begin
            op = OP_ALIGN;
        end
        else if (pick < 86)
        begin
            op = OP_BITS_LEFT;
        end
        else
        begin
            op = OP_MORE_DATA;
        end
        send_command(op, rand_count(), 8'($urandom_range(255)));
    endtask

    // Loads a buffer of Exp-Golomb codes with random content and then decodes it,
    // usually running a little past the end.
    task automatic run_stream();
        bit                   stream_bits[$];
        logic [BYTE_BITS-1:0] packed_byte;
        int                   ncodes;
        int                   pick;
        int                   zeros;
        int                   i;
        int                   j;
        if ($urandom_range(9) != 0)
        begin
            send_command(OP_START, rand_count(), 8'($urandom_range(255)));
        end
        ncodes = $urandom_range(5, 1);
        repeat (ncodes)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
            begin
                repeat ($urandom_range(16, 1))
                begin
                    stream_bits.push_back(1'($urandom_range(1)));
                end
            end
            else
            begin
                // Long prefixes reach the 32 zero limit now and then.
                zeros = (pick == 1) ? $urandom_range(33, 8) : $urandom_range(4, 0);
                repeat (zeros)
                begin
                    stream_bits.push_back(1'b0);
                end
                stream_bits.push_back(1'b1);
                repeat (zeros)
                begin
                    stream_bits.push_back(1'($urandom_range(1)));
                end
            end
        end
        if ($urandom_range(1))
        begin
            stream_bits.push_back(1'b1);
        end
        while (stream_bits.size() % BYTE_BITS != 0)
        begin
            stream_bits.push_back(1'b0);
        end
        for (i = 0; i < stream_bits.size(); i += BYTE_BITS)
        begin
            packed_byte = '0;
            for (j = 0; j < BYTE_BITS; j++)
            begin
                packed_byte = {packed_byte[BYTE_BITS-2:0], stream_bits[i + j]};
            end
            send_command(OP_APPEND, rand_count(), packed_byte);
        end
        repeat (ncodes + $urandom_range(5, 1))
        begin
            random_command();
        end
    endtask

    task automatic run_phase();
        int target;
        target = commands_sent + ITEMS_PER_PHASE;
        while (commands_sent < target)
        begin
            if ($urandom_range(7) == 0)
            begin
                repeat ($urandom_range(4, 1))
                begin
                    send_command(4'($urandom_range(OP_LAST_UNUSED)), 6'($urandom_range(63)),
                                 8'($urandom_range(255)));
                end
            end
            else
            begin
                run_stream();
            end
            if ($urandom_range(19) == 0)
            begin
                wait_for_replies();
            end
        end
        wait_for_replies();
    endtask

    task automatic run_directed();
        send_command(OP_MORE_DATA, 6'd0, 8'h00);
        send_command(OP_BITS_LEFT, 6'd63, 8'hFF);
        send_command(OP_FIRST_UNUSED, 6'd0, 8'h00);
        send_command(OP_LAST_UNUSED, 6'd63, 8'hFF);
        repeat (4)
        begin
            send_command(OP_APPEND, 6'd0, 8'h00);
        end
        send_command(OP_APPEND, 6'd0, 8'h80);
        send_command(OP_APPEND, 6'd63, 8'hFF);
        // Thirty-two leading zeros: consumed, value zero, error raised.
        send_command(OP_UE, 6'd0, 8'h00);
        send_command(OP_MORE_DATA, 6'd0, 8'h00);
        send_command(OP_SE, 6'd0, 8'h00);
        send_command(OP_ALIGN, 6'd0, 8'h00);
        send_command(OP_ALIGN, 6'd0, 8'h00);
        send_command(OP_READ, 6'd4, 8'h00);
        send_command(OP_PEEK, 6'd63, 8'h00);
        send_command(OP_SKIP, 6'd0, 8'h00);
        send_command(OP_READ, 6'd32, 8'h00);
        // A prefix of seven zeros whose suffix lies beyond the end of the buffer.
        send_command(OP_START, 6'd63, 8'hFF);
        send_command(OP_APPEND, 6'd0, 8'h01);
        send_command(OP_UE, 6'd0, 8'h00);
        // The buffer ends while the prefix is still being counted.
        send_command(OP_START, 6'd0, 8'h00);
        send_command(OP_APPEND, 6'd0, 8'h00);
        send_command(OP_SE, 6'd0, 8'h00);
        send_command(OP_BITS_LEFT, 6'd0, 8'h00);
        send_command(OP_MORE_DATA, 6'd0, 8'h00);
        wait_for_replies();
    endtask

    initial
    begin
        idle_pct = 36;
        repeat (RESET_CYCLES)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_phase();
        idle_pct = 77;
        run_phase();
        idle_pct = 0;
        run_phase();
        repeat (TAIL_CYCLES)
        begin
            @(posedge clk);
        end
        $display("Covered %0d commands over three pacing regimes, with reads past the end.",
                 commands_sent);
        $display("%0d results compared, %0d mismatches.", replies_checked, mismatch_count);
        if (mismatch_count == 0 && replies_outstanding == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
